// ----- sv/pulse_segmenter_area_peak_top_macros.svh -----
// Assertion macros for the pulse segmenter checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PULSE_SEGMENTER_AREA_PEAK_TOP_MACROS_SVH
`define PULSE_SEGMENTER_AREA_PEAK_TOP_MACROS_SVH

// same-cycle implication
`define PSEG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pseg check failed");

// next-cycle implication
`define PSEG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pseg check failed");

`endif

// ----- sv/pseg_pkg.sv -----
// Shared types and constants for the pulse segmenter.
// No dependencies.
`default_nettype none
package pseg_pkg;

	localparam int RECORD_LENGTH = 4096;
	localparam int SAMPLE_W = 16;
	localparam int IDX_W = 12;
	localparam int AREA_W = 28;
	localparam int RUN_W = 8;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIGGER_LEVEL = 3'd0,
		REG_PEDESTAL_LEVEL = 3'd1,
		REG_QUIET_UPPER = 3'd2,
		REG_QUIET_RUN_LENGTH = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] trigger_level;
		logic signed [SAMPLE_W-1:0] pedestal_level;
		logic signed [SAMPLE_W-1:0] quiet_upper;
		logic [RUN_W-1:0] quiet_run_length;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] start_index;
		logic [IDX_W-1:0] end_index;
		logic [AREA_W-1:0] area;
		logic signed [SAMPLE_W-1:0] peak;
		logic complete;
	} result_t;

endpackage
`default_nettype wire

// ----- sv/pulse_segmenter_area_peak_top.sv -----
// Channel  | Dir | Handshake            | Word
// ---------+-----+----------------------+---------------------------------------
// in       | in  | in_valid / in_stall  | sample, record_last
// out      | out | out_valid / out_stall| start_index, end_index, area, peak, complete
// cfg      | in  | cfg_wr_en            | cfg_index, cfg_data
//
// One word per cycle sustained while no stalled result holds the input stage.
// Words go through an input register, then the tracking logic into the result register.
// A stalled result holds the input stage; the input stage still takes a word while empty.
// Reset clears the pulse state and loads the register defaults; no clearing pass.
// Top level of the pulse segmenter. Depends on pseg_pkg, pseg_cfg and pseg_core.
`default_nettype none
module pulse_segmenter_area_peak_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [pseg_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [pseg_pkg::SAMPLE_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [pseg_pkg::SAMPLE_W-1:0] sample,
	input wire logic record_last,
	output logic out_valid,
	input wire logic out_stall,
	output logic [pseg_pkg::IDX_W-1:0] start_index,
	output logic [pseg_pkg::IDX_W-1:0] end_index,
	output logic [pseg_pkg::AREA_W-1:0] area,
	output logic signed [pseg_pkg::SAMPLE_W-1:0] peak,
	output logic complete
);
	import pseg_pkg::*;

	cfg_t cfg;
	result_t res, res_q;
	logic res_valid;
	logic valid_s1, adv_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic record_last_s1;
	logic out_valid_q;

	pseg_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// advance the input stage whenever the result register is free or draining
	assign adv_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample;
			record_last_s1 <= record_last;
		end
	end

	pseg_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.step(adv_s1),
		.sample_s1(sample_s1),
		.record_last_s1(record_last_s1),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign start_index = res_q.start_index;
	assign end_index = res_q.end_index;
	assign area = res_q.area;
	assign peak = res_q.peak;
	assign complete = res_q.complete;
endmodule
`default_nettype wire

// ----- sv/pseg_cfg.sv -----
// Configuration register file for the pulse segmenter.
// Depends on pseg_pkg.
`default_nettype none
module pseg_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [pseg_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [pseg_pkg::SAMPLE_W-1:0] cfg_data,
	output pseg_pkg::cfg_t cfg
);
	import pseg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_level <= -16'sd100;
			cfg_q.pedestal_level <= -16'sd50;
			cfg_q.quiet_upper <= 16'sd20;
			cfg_q.quiet_run_length <= 8'd18;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TRIGGER_LEVEL: cfg_q.trigger_level <= cfg_data;
				REG_PEDESTAL_LEVEL: cfg_q.pedestal_level <= cfg_data;
				REG_QUIET_UPPER: cfg_q.quiet_upper <= cfg_data;
				REG_QUIET_RUN_LENGTH: cfg_q.quiet_run_length <= cfg_data[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// ----- sv/pseg_core.sv -----
// Per-sample pulse tracking: trigger, quiet-run count, area and peak.
// Depends on pseg_pkg. Updates its state on every step pulse.
`default_nettype none
module pseg_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire pseg_pkg::cfg_t cfg,
	input wire logic step,
	input wire logic signed [pseg_pkg::SAMPLE_W-1:0] sample_s1,
	input wire logic record_last_s1,
	output logic res_valid,
	output pseg_pkg::result_t res
);
	import pseg_pkg::*;

	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
	localparam logic [31:0] LAST_IDX = 32'(RECORD_LENGTH - 1);

	function automatic logic [AREA_W-1:0] sat_add(input logic [AREA_W-1:0] a,
			input logic [AREA_W-1:0] b);
		logic [AREA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[AREA_W] ? AREA_MAX : s[AREA_W-1:0];
	endfunction

	logic [IDX_W-1:0] sample_index_q, pulse_start_q, quiet_begin_q;
	logic in_pulse_q;
	logic [RUN_W-1:0] quiet_count_q;
	logic [AREA_W-1:0] area_sum_q, quiet_area_q;
	logic signed [SAMPLE_W-1:0] peak_min_q, quiet_min_q;

	logic [IDX_W-1:0] sample_index_d, pulse_start_d, quiet_begin_d;
	logic in_pulse_d;
	logic [RUN_W-1:0] quiet_count_d;
	logic [AREA_W-1:0] area_sum_d, quiet_area_d;
	logic signed [SAMPLE_W-1:0] peak_min_d, quiet_min_d;

	logic last, trig, active, quiet, done;
	logic [RUN_W-1:0] need, qc_base, qc_inc;
	logic [AREA_W-1:0] area_base, qa_base, area_fold, mag28;
	logic signed [SAMPLE_W-1:0] peak_base, qmin_base, peak_fold;
	logic signed [SAMPLE_W:0] sx;
	logic [SAMPLE_W:0] mag;

	always_comb begin
		last = record_last_s1 || ({{(32-IDX_W){1'b0}}, sample_index_q} == LAST_IDX);
		need = (cfg.quiet_run_length == '0) ? RUN_W'(1) : cfg.quiet_run_length;
		sx = {sample_s1[SAMPLE_W-1], sample_s1};
		mag = sample_s1[SAMPLE_W-1] ? $unsigned(-sx) : $unsigned(sx);
		mag28 = {{(AREA_W-SAMPLE_W-1){1'b0}}, mag};

		trig = !in_pulse_q && (sample_s1 <= cfg.trigger_level);
		active = in_pulse_q || trig;
		quiet = (sample_s1 >= cfg.pedestal_level) && (sample_s1 < cfg.quiet_upper);

		// a fresh pulse starts from cleared accumulators
		qc_base = trig ? '0 : quiet_count_q;
		area_base = trig ? '0 : area_sum_q;
		peak_base = trig ? '0 : peak_min_q;

		qa_base = (qc_base == '0) ? '0 : quiet_area_q;
		qmin_base = (qc_base == '0) ? '0 : quiet_min_q;
		qc_inc = qc_base + RUN_W'(1);
		done = active && quiet && (qc_inc >= need);

		// broken quiet run folds back into the pulse
		area_fold = (qc_base != '0) ? sat_add(area_base, quiet_area_q) : area_base;
		peak_fold = ((qc_base != '0) && (quiet_min_q < peak_base)) ? quiet_min_q : peak_base;

		sample_index_d = last ? '0 : sample_index_q + IDX_W'(1);
		in_pulse_d = in_pulse_q;
		pulse_start_d = pulse_start_q;
		quiet_begin_d = quiet_begin_q;
		quiet_count_d = quiet_count_q;
		area_sum_d = area_sum_q;
		quiet_area_d = quiet_area_q;
		peak_min_d = peak_min_q;
		quiet_min_d = quiet_min_q;

		res_valid = 1'b0;
		res.start_index = trig ? sample_index_q : pulse_start_q;
		res.end_index = '0;
		res.area = '0;
		res.peak = '0;
		res.complete = 1'b0;

		if (active) begin
			in_pulse_d = 1'b1;
			pulse_start_d = res.start_index;
			area_sum_d = area_base;
			peak_min_d = peak_base;
			if (quiet) begin
				quiet_begin_d = (qc_base == '0) ? sample_index_q : quiet_begin_q;
				quiet_area_d = sat_add(qa_base, mag28);
				quiet_min_d = (sample_s1 < qmin_base) ? sample_s1 : qmin_base;
				quiet_count_d = qc_inc;
				if (done) begin
					res_valid = 1'b1;
					res.end_index = quiet_begin_d;
					res.area = area_base;
					res.peak = peak_base;
					res.complete = 1'b1;
					in_pulse_d = 1'b0;
					quiet_count_d = '0;
				end
			end else begin
				quiet_count_d = '0;
				area_sum_d = sat_add(area_fold, mag28);
				peak_min_d = (sample_s1 < peak_fold) ? sample_s1 : peak_fold;
			end
		end

		// record end with pulse still open: report it incomplete
		if (last && in_pulse_d) begin
			res_valid = 1'b1;
			in_pulse_d = 1'b0;
			quiet_count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
			in_pulse_q <= 1'b0;
			pulse_start_q <= '0;
			quiet_count_q <= '0;
			quiet_begin_q <= '0;
			area_sum_q <= '0;
			quiet_area_q <= '0;
			peak_min_q <= '0;
			quiet_min_q <= '0;
		end else if (step) begin
			sample_index_q <= sample_index_d;
			in_pulse_q <= in_pulse_d;
			pulse_start_q <= pulse_start_d;
			quiet_count_q <= quiet_count_d;
			quiet_begin_q <= quiet_begin_d;
			area_sum_q <= area_sum_d;
			quiet_area_q <= quiet_area_d;
			peak_min_q <= peak_min_d;
			quiet_min_q <= quiet_min_d;
		end
	end
endmodule
`default_nettype wire

// ----- sv/pseg_checker.sv -----
// Port-level checks for the pulse segmenter, bound to the top level.
// Depends on pseg_pkg and the macro header.
`default_nettype none
`include "pulse_segmenter_area_peak_top_macros.svh"
module pseg_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [pseg_pkg::IDX_W-1:0] start_index,
	input wire logic [pseg_pkg::IDX_W-1:0] end_index,
	input wire logic [pseg_pkg::AREA_W-1:0] area,
	input wire logic signed [pseg_pkg::SAMPLE_W-1:0] peak,
	input wire logic complete
);
	import pseg_pkg::*;

	`PSEG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`PSEG_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(start_index) && $stable(complete))
	`PSEG_ASSERT_NOW(a_incomplete_zero, out_valid && !complete, end_index == '0 && area == '0 && peak == '0)
	`PSEG_ASSERT_NOW(a_peak_nonpos, out_valid, peak[SAMPLE_W-1] || peak == '0)
endmodule

bind pulse_segmenter_area_peak_top pseg_checker u_pseg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.start_index(start_index),
	.end_index(end_index),
	.area(area),
	.peak(peak),
	.complete(complete)
);
`default_nettype wire
